// ===== sv/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the round-robin IO block scheduler
// Holds the item and result layouts, the status codes and the defaults of
// the top-level parameters.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // defaults for the top-level parameters
  localparam int MAX_PROCS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 32;

  // io hold time value after reset
  localparam logic [7:0] IO_HOLD_RST = 8'd4;

  // command codes carried in in_tuser
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // result status codes carried in out_tuser
  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_RAN      = 3'd2,
    ST_IO       = 3'd3,
    ST_IDLE     = 3'd4,
    ST_DONE_ALL = 3'd5
  } status_t;

  // one input item
  typedef struct packed {
    cmd_t        command;
    logic [15:0] process_id;
    logic [15:0] instruction_count;
    logic        is_cpu;
  } item_t;

  // one result item
  typedef struct packed {
    status_t     status;
    logic [15:0] served_id;
    logic        process_done;
    logic [31:0] elapsed_time;
    logic [31:0] cpu_cycle_count;
    logic [31:0] io_cycle_count;
  } result_t;

endpackage

// ===== sv/rrs_sched.sv =====
// ----------------------------------------------------------------------------
// rrs_sched: scheduler state and combinational step
// Holds the ready and blocked queues and the counters, and works out one
// load or tick per enabled cycle, giving its result combinationally.
// ----------------------------------------------------------------------------
module rrs_sched #(
  parameter int MAX_PROCS  = rrs_pkg::MAX_PROCS_DEF,
  parameter int TIME_WIDTH = rrs_pkg::TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  rrs_pkg::item_t   item,
  input  logic [7:0]       io_hold,
  output rrs_pkg::result_t result
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);
  localparam logic [CNT_W:0]   FULL_CNT = (CNT_W + 1)'(MAX_PROCS);

  // queue storage
  logic [15:0]           rdy_id_r    [MAX_PROCS];
  logic [15:0]           rdy_cnt_r   [MAX_PROCS];
  logic                  rdy_cpu_r   [MAX_PROCS];
  logic [15:0]           blk_id_r    [MAX_PROCS];
  logic [15:0]           blk_cnt_r   [MAX_PROCS];
  logic [TIME_WIDTH-1:0] blk_stamp_r [MAX_PROCS];

  // queue pointers and counters
  logic [IDX_W-1:0]      rdy_head_r, rdy_head_nxt, rdy_tail_r, rdy_tail_nxt;
  logic [CNT_W-1:0]      rdy_used_r, rdy_used_nxt;
  logic [IDX_W-1:0]      blk_head_r, blk_head_nxt, blk_tail_r, blk_tail_nxt;
  logic [CNT_W-1:0]      blk_used_r, blk_used_nxt;
  logic [TIME_WIDTH-1:0] tick_r, tick_nxt;
  logic [31:0]           busy_r, busy_nxt;
  logic [31:0]           wait_r, wait_nxt;

  // write ports: two on the ready queue, one on the blocked queue
  logic                  rwa_en, rwb_en, bw_en;
  logic [IDX_W-1:0]      rwa_idx, rwb_idx;
  logic [15:0]           rwa_id, rwa_cnt, rwb_id, rwb_cnt;
  logic                  rwa_cpu;
  logic [TIME_WIDTH-1:0] bw_stamp;

  // ready head and blocked head as seen after this step's IO push
  logic [15:0]           hd_id, hd_cnt;
  logic                  hd_cpu;
  logic [15:0]           bh_id, bh_cnt;
  logic [TIME_WIDTH-1:0] bh_stamp, bh_due, tick_inc;
  logic [CNT_W:0]        total_used;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    next_slot = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  assign hd_id      = rdy_id_r[rdy_head_r];
  assign hd_cnt     = rdy_cnt_r[rdy_head_r];
  assign hd_cpu     = rdy_cpu_r[rdy_head_r];
  assign tick_inc   = tick_r + TIME_WIDTH'(1);
  assign total_used = {1'b0, rdy_used_r} + {1'b0, blk_used_r};

  // blocked head, bypassing an entry pushed into an empty blocked queue
  always_comb begin
    if (blk_used_r == '0) begin
      bh_id    = hd_id;
      bh_cnt   = hd_cnt;
      bh_stamp = tick_inc;
    end else begin
      bh_id    = blk_id_r[blk_head_r];
      bh_cnt   = blk_cnt_r[blk_head_r];
      bh_stamp = blk_stamp_r[blk_head_r];
    end
    bh_due = bh_stamp + TIME_WIDTH'(io_hold);
  end

  // one scheduler step
  always_comb begin
    rdy_head_nxt = rdy_head_r;
    rdy_tail_nxt = rdy_tail_r;
    rdy_used_nxt = rdy_used_r;
    blk_head_nxt = blk_head_r;
    blk_tail_nxt = blk_tail_r;
    blk_used_nxt = blk_used_r;
    tick_nxt     = tick_r;
    busy_nxt     = busy_r;
    wait_nxt     = wait_r;
    rwa_en       = 1'b0;
    rwa_idx      = rdy_tail_r;
    rwa_id       = item.process_id;
    rwa_cnt      = item.instruction_count;
    rwa_cpu      = item.is_cpu;
    rwb_en       = 1'b0;
    rwb_idx      = rdy_tail_r;
    rwb_id       = bh_id;
    rwb_cnt      = bh_cnt;
    bw_en        = 1'b0;
    bw_stamp     = tick_inc;
    result.status       = rrs_pkg::ST_DONE_ALL;
    result.served_id    = '0;
    result.process_done = 1'b0;

    if (item.command == rrs_pkg::CMD_LOAD) begin
      if (total_used >= FULL_CNT) begin
        result.status = rrs_pkg::ST_FULL;
      end else begin
        rwa_en        = 1'b1;
        rdy_tail_nxt  = next_slot(rdy_tail_r);
        rdy_used_nxt  = rdy_used_r + CNT_W'(1);
        result.status = rrs_pkg::ST_LOADED;
      end
    end else if (total_used != '0) begin
      tick_nxt = tick_inc;
      if (rdy_used_r == '0) begin
        // nothing ready: an idle tick, counted as IO wait
        wait_nxt      = wait_r + 32'd1;
        result.status = rrs_pkg::ST_IDLE;
      end else begin
        // serve the ready head
        rdy_head_nxt     = next_slot(rdy_head_r);
        rdy_used_nxt     = rdy_used_r - CNT_W'(1);
        busy_nxt         = busy_r + 32'd1;
        result.served_id = hd_id;
        if (hd_cpu) begin
          result.status = rrs_pkg::ST_RAN;
          if (hd_cnt <= 16'd1) begin
            result.process_done = 1'b1;
          end else begin
            rwa_en       = 1'b1;
            rwa_id       = hd_id;
            rwa_cnt      = hd_cnt - 16'd1;
            rwa_cpu      = 1'b1;
            rdy_tail_nxt = next_slot(rdy_tail_r);
            rdy_used_nxt = rdy_used_r;
          end
        end else begin
          result.status = rrs_pkg::ST_IO;
          bw_en         = 1'b1;
          blk_tail_nxt  = next_slot(blk_tail_r);
          blk_used_nxt  = blk_used_r + CNT_W'(1);
        end
      end
      // release the blocked head once its IO time is over
      if (blk_used_nxt != '0) begin
        if (bh_due == tick_inc) begin
          rwb_en       = 1'b1;
          rwb_idx      = rdy_tail_nxt;
          rdy_tail_nxt = next_slot(rdy_tail_nxt);
          rdy_used_nxt = rdy_used_nxt + CNT_W'(1);
          blk_head_nxt = next_slot(blk_head_r);
          blk_used_nxt = blk_used_nxt - CNT_W'(1);
        end
        if (blk_used_nxt != '0) begin
          wait_nxt = wait_nxt + 32'd1;
        end
      end
    end

    result.elapsed_time    = 32'(tick_nxt);
    result.cpu_cycle_count = busy_nxt;
    result.io_cycle_count  = wait_nxt;
  end

  // queue storage writes
  always_ff @(posedge clk) begin
    if (step_en) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        if (rwa_en && rwa_idx == IDX_W'(i)) begin
          rdy_id_r[i]  <= rwa_id;
          rdy_cnt_r[i] <= rwa_cnt;
          rdy_cpu_r[i] <= rwa_cpu;
        end
        if (rwb_en && rwb_idx == IDX_W'(i)) begin
          rdy_id_r[i]  <= rwb_id;
          rdy_cnt_r[i] <= rwb_cnt;
          rdy_cpu_r[i] <= 1'b1;
        end
        if (bw_en && blk_tail_r == IDX_W'(i)) begin
          blk_id_r[i]    <= hd_id;
          blk_cnt_r[i]   <= hd_cnt;
          blk_stamp_r[i] <= bw_stamp;
        end
      end
    end
  end

  // pointers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_head_r <= '0;
      rdy_tail_r <= '0;
      rdy_used_r <= '0;
      blk_head_r <= '0;
      blk_tail_r <= '0;
      blk_used_r <= '0;
      tick_r     <= '0;
      busy_r     <= '0;
      wait_r     <= '0;
    end else if (step_en) begin
      rdy_head_r <= rdy_head_nxt;
      rdy_tail_r <= rdy_tail_nxt;
      rdy_used_r <= rdy_used_nxt;
      blk_head_r <= blk_head_nxt;
      blk_tail_r <= blk_tail_nxt;
      blk_used_r <= blk_used_nxt;
      tick_r     <= tick_nxt;
      busy_r     <= busy_nxt;
      wait_r     <= wait_nxt;
    end
  end

`ifndef ASSERT_OFF
  // both queues together never hold more than the store
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_used <= FULL_CNT)
    else $error("rrs_sched: queues exceed capacity");

  // an empty ready queue has its pointers together
  a_rdy_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    rdy_used_r == '0 |-> rdy_head_r == rdy_tail_r)
    else $error("rrs_sched: ready pointers apart while empty");

  // an empty blocked queue has its pointers together
  a_blk_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    blk_used_r == '0 |-> blk_head_r == blk_tail_r)
    else $error("rrs_sched: blocked pointers apart while empty");

  // a finished tick lets no time pass
  a_done_still: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && result.status == rrs_pkg::ST_DONE_ALL |=> $stable(tick_r) && $stable(wait_r))
    else $error("rrs_sched: time moved on a finished tick");

  // a load never moves the counters
  a_load_still: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.command == rrs_pkg::CMD_LOAD |=> $stable(tick_r) && $stable(busy_r))
    else $error("rrs_sched: counters moved on a load");
`endif

endmodule

// ===== sv/round_robin_io_block_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_io_block_scheduler_core: round-robin scheduler with IO blocking
// Stream wrapper around the scheduler step: input register, step, result
// register, plus the io hold time configuration register.
// ----------------------------------------------------------------------------
// Takes one load or tick transfer per clock while out_tready stays high and
// gives one result for each. A transfer is captured in the input register,
// the scheduler step runs out of that register once the result register is
// free or being emptied, and its result lands in the output register, which
// offers it on out_tvalid; the sustained rate is one item per cycle while
// out_tready stays high.
// The rate is set by the combinational step: one ready pop, up to two ready
// pushes, one blocked push and one blocked-head compare. Write the io hold
// time only while no item is in flight.
module round_robin_io_block_scheduler_core #(
  parameter int MAX_PROCS  = rrs_pkg::MAX_PROCS_DEF,
  parameter int TIME_WIDTH = rrs_pkg::TIME_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // process_id, instruction_count, is_cpu, pad
  input  logic         in_tuser,   // command
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // served_id, process_done, elapsed_time,
                                   // cpu_cycle_count, io_cycle_count, pad
  output logic [2:0]   out_tuser,  // status
  // configuration
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  logic             in_valid_r;
  rrs_pkg::item_t   in_item_r;
  logic             out_valid_r;
  rrs_pkg::result_t out_res_r;
  rrs_pkg::result_t step_res;
  logic [7:0]       io_hold_r;
  logic             advance;

  // step runs when the result register is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_hold_r <= rrs_pkg::IO_HOLD_RST;
    end else if (cfg_wr_en) begin
      io_hold_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.command           <= rrs_pkg::cmd_t'(in_tuser);
      in_item_r.process_id        <= in_tdata[15:0];
      in_item_r.instruction_count <= in_tdata[31:16];
      in_item_r.is_cpu            <= in_tdata[32];
    end
  end

  // scheduler step
  rrs_sched #(
    .MAX_PROCS  (MAX_PROCS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_sched (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item        (in_item_r),
    .io_hold     (io_hold_r),
    .result      (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'b0, out_res_r.io_cycle_count, out_res_r.cpu_cycle_count,
                       out_res_r.elapsed_time, out_res_r.process_done,
                       out_res_r.served_id};

endmodule
